// ===== rtl/core/yuv420_block_anaglyph_filter_top_assert.svh =====
// assertion macros for the anaglyph filter
`ifndef YUV420_BLOCK_ANAGLYPH_FILTER_TOP_ASSERT_SVH
`define YUV420_BLOCK_ANAGLYPH_FILTER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define YAF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("anaglyph filter check failed");

// next-cycle implication, disabled while reset is asserted
`define YAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("anaglyph filter check failed");

`endif

// ===== rtl/core/yaf_pkg.sv =====
package yaf_pkg;

	localparam int FRAC_BITS = 13;
	localparam int NPIX = 4;

	typedef logic [7:0] sample_t;
	// forward-path accumulator, holds the rgb sums before the shift
	typedef logic signed [23:0] acc_t;
	// one unclamped rgb channel
	typedef logic signed [10:0] chan_t;
	// back-path sum of three products and rounding terms
	typedef logic signed [25:0] wsum_t;
	// magnitude after abs and shift
	typedef logic [10:0] mag_t;

	typedef struct packed {
		logic adv;
		logic eye_mode;
	} pipe_ctrl_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} rgb_t;

	localparam logic signed [8:0] LUMA_OFS = 9'sd16;
	localparam logic signed [8:0] CHROMA_OFS = 9'sd128;

	localparam acc_t K_Y  = 24'sd9535;
	localparam acc_t K_RV = 24'sd13074;
	localparam acc_t K_GV = 24'sd6660;
	localparam acc_t K_GU = 24'sd3203;
	localparam acc_t K_BU = 24'sd16531;

	localparam wsum_t K_YR = 26'sd2104;
	localparam wsum_t K_YG = 26'sd4130;
	localparam wsum_t K_YB = 26'sd802;
	localparam wsum_t K_UR = -26'sd1214;
	localparam wsum_t K_UG = -26'sd2384;
	localparam wsum_t K_UB = 26'sd3598;
	localparam wsum_t K_VR = 26'sd3598;
	localparam wsum_t K_VG = -26'sd3013;
	localparam wsum_t K_VB = -26'sd585;
	localparam wsum_t RND_Y = 26'sd4096 + 26'sd131072;
	localparam wsum_t RND_C = 26'sd4096 + 26'sd1048576;

	function automatic mag_t abs_shift(input wsum_t x);
		wsum_t m;
		m = x[$bits(wsum_t)-1] ? -x : x;
		return m[FRAC_BITS +: $bits(mag_t)];
	endfunction

	function automatic sample_t clamp8(input mag_t v);
		return (v > mag_t'(255)) ? 8'hFF : v[7:0];
	endfunction

endpackage

// ===== rtl/core/yaf_if.sv =====
// block word: four luma samples and the shared chroma pair
interface yaf_in_if;
	logic valid;
	logic ready;
	yaf_pkg::sample_t luma_top_left;
	yaf_pkg::sample_t luma_top_right;
	yaf_pkg::sample_t luma_bottom_left;
	yaf_pkg::sample_t luma_bottom_right;
	yaf_pkg::sample_t chroma_blue;
	yaf_pkg::sample_t chroma_red;

	modport source(output valid, luma_top_left, luma_top_right, luma_bottom_left,
		luma_bottom_right, chroma_blue, chroma_red, input ready);
	modport sink(input valid, luma_top_left, luma_top_right, luma_bottom_left,
		luma_bottom_right, chroma_blue, chroma_red, output ready);
endinterface

// filtered block word
interface yaf_out_if;
	logic valid;
	logic ready;
	yaf_pkg::sample_t out_luma_top_left;
	yaf_pkg::sample_t out_luma_top_right;
	yaf_pkg::sample_t out_luma_bottom_left;
	yaf_pkg::sample_t out_luma_bottom_right;
	yaf_pkg::sample_t out_chroma_blue;
	yaf_pkg::sample_t out_chroma_red;

	modport source(output valid, out_luma_top_left, out_luma_top_right,
		out_luma_bottom_left, out_luma_bottom_right, out_chroma_blue, out_chroma_red,
		input ready);
	modport sink(input valid, out_luma_top_left, out_luma_top_right,
		out_luma_bottom_left, out_luma_bottom_right, out_chroma_blue, out_chroma_red,
		output ready);
endinterface

// eye mode write word
interface yaf_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ===== rtl/core/yaf_rgb.sv =====
module yaf_rgb (
	input  logic                clk,
	input  yaf_pkg::pipe_ctrl_t ctrl,
	input  yaf_pkg::sample_t    luma [yaf_pkg::NPIX],
	input  yaf_pkg::sample_t    cb,
	input  yaf_pkg::sample_t    cr,
	output yaf_pkg::rgb_t       rgb_s2 [yaf_pkg::NPIX]
);
	import yaf_pkg::*;

	logic signed [8:0] ut;
	logic signed [8:0] vt;
	logic signed [8:0] yd [NPIX];
	acc_t yt_s1 [NPIX];
	acc_t tr_s1;
	acc_t tg_s1;
	acc_t tb_s1;
	acc_t rs [NPIX];
	acc_t gs [NPIX];
	acc_t bs [NPIX];

	always_comb begin
		ut = $signed({1'b0, cb}) - CHROMA_OFS;
		vt = $signed({1'b0, cr}) - CHROMA_OFS;
		for (int i = 0; i < NPIX; i++) begin
			yd[i] = $signed({1'b0, luma[i]}) - LUMA_OFS;
		end
	end

	// stage 1: luma and chroma products
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			for (int i = 0; i < NPIX; i++) begin
				yt_s1[i] <= acc_t'(yd[i]) * K_Y;
			end
			tr_s1 <= acc_t'(vt) * K_RV;
			tg_s1 <= acc_t'(vt) * K_GV + acc_t'(ut) * K_GU;
			tb_s1 <= acc_t'(ut) * K_BU;
		end
	end

	always_comb begin
		for (int i = 0; i < NPIX; i++) begin
			rs[i] = yt_s1[i] + tr_s1;
			gs[i] = yt_s1[i] - tg_s1;
			bs[i] = yt_s1[i] + tb_s1;
		end
	end

	// stage 2: floor shift by taking the upper bits
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			for (int i = 0; i < NPIX; i++) begin
				rgb_s2[i].r <= rs[i][FRAC_BITS +: $bits(chan_t)];
				rgb_s2[i].g <= gs[i][FRAC_BITS +: $bits(chan_t)];
				rgb_s2[i].b <= bs[i][FRAC_BITS +: $bits(chan_t)];
			end
		end
	end

endmodule

// ===== rtl/core/yaf_recode.sv =====
module yaf_recode (
	input  logic                clk,
	input  yaf_pkg::pipe_ctrl_t ctrl,
	input  yaf_pkg::rgb_t       rgb_s2 [yaf_pkg::NPIX],
	output yaf_pkg::sample_t    y_s5 [yaf_pkg::NPIX],
	output yaf_pkg::mag_t       u_s5 [yaf_pkg::NPIX],
	output yaf_pkg::mag_t       v_s5 [yaf_pkg::NPIX]
);
	import yaf_pkg::*;

	logic signed [11:0] gb [NPIX];
	logic signed [11:0] half [NPIX];
	rgb_t rgb_s3 [NPIX];
	wsum_t prod_s4 [NPIX][9];
	wsum_t ysum [NPIX];
	wsum_t usum [NPIX];
	wsum_t vsum [NPIX];

	// red edit, mean of green and blue truncated toward zero
	always_comb begin
		for (int i = 0; i < NPIX; i++) begin
			gb[i] = 12'(rgb_s2[i].g) + 12'(rgb_s2[i].b);
			half[i] = gb[i] + $signed({11'b0, gb[i][11]});
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			for (int i = 0; i < NPIX; i++) begin
				rgb_s3[i].r <= ctrl.eye_mode ? chan_t'(0) : chan_t'(half[i][11:1]);
				rgb_s3[i].g <= rgb_s2[i].g;
				rgb_s3[i].b <= rgb_s2[i].b;
			end
		end
	end

	// stage 4: nine constant products per pixel
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			for (int i = 0; i < NPIX; i++) begin
				prod_s4[i][0] <= wsum_t'(rgb_s3[i].r) * K_YR;
				prod_s4[i][1] <= wsum_t'(rgb_s3[i].g) * K_YG;
				prod_s4[i][2] <= wsum_t'(rgb_s3[i].b) * K_YB;
				prod_s4[i][3] <= wsum_t'(rgb_s3[i].r) * K_UR;
				prod_s4[i][4] <= wsum_t'(rgb_s3[i].g) * K_UG;
				prod_s4[i][5] <= wsum_t'(rgb_s3[i].b) * K_UB;
				prod_s4[i][6] <= wsum_t'(rgb_s3[i].r) * K_VR;
				prod_s4[i][7] <= wsum_t'(rgb_s3[i].g) * K_VG;
				prod_s4[i][8] <= wsum_t'(rgb_s3[i].b) * K_VB;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NPIX; i++) begin
			ysum[i] = prod_s4[i][0] + prod_s4[i][1] + prod_s4[i][2] + RND_Y;
			usum[i] = prod_s4[i][3] + prod_s4[i][4] + prod_s4[i][5] + RND_C;
			vsum[i] = prod_s4[i][6] + prod_s4[i][7] + prod_s4[i][8] + RND_C;
		end
	end

	// stage 5: magnitude, shift, luma clamp
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			for (int i = 0; i < NPIX; i++) begin
				y_s5[i] <= clamp8(abs_shift(ysum[i]));
				u_s5[i] <= abs_shift(usum[i]);
				v_s5[i] <= abs_shift(vsum[i]);
			end
		end
	end

endmodule

// ===== rtl/core/yaf_avg.sv =====
module yaf_avg (
	input  logic                clk,
	input  yaf_pkg::pipe_ctrl_t ctrl,
	input  yaf_pkg::sample_t    y_s5 [yaf_pkg::NPIX],
	input  yaf_pkg::mag_t       u_s5 [yaf_pkg::NPIX],
	input  yaf_pkg::mag_t       v_s5 [yaf_pkg::NPIX],
	output yaf_pkg::sample_t    luma_s6 [yaf_pkg::NPIX],
	output yaf_pkg::sample_t    cb_s6,
	output yaf_pkg::sample_t    cr_s6
);
	import yaf_pkg::*;

	logic [$bits(mag_t)+1:0] usum;
	logic [$bits(mag_t)+1:0] vsum;

	always_comb begin
		usum = '0;
		vsum = '0;
		for (int i = 0; i < NPIX; i++) begin
			usum = usum + ($bits(usum))'(u_s5[i]);
			vsum = vsum + ($bits(vsum))'(v_s5[i]);
		end
	end

	// divide by four is a shift, sums are never negative
	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			luma_s6 <= y_s5;
			cb_s6 <= clamp8(usum[$bits(usum)-1:2]);
			cr_s6 <= clamp8(vsum[$bits(vsum)-1:2]);
		end
	end

endmodule

// ===== rtl/core/yuv420_block_anaglyph_filter_top.sv =====
// yuv 4:2:0 block anaglyph filter. one word is a 2x2 block (four luma samples and the
// shared u/v pair); every accepted word leaves the output register as one filtered word,
// in the order of acceptance. the six register stages are: chroma and luma products,
// rgb sums with floor shift, red edit by eye mode, nine constant products per pixel,
// magnitude/shift/luma clamp, and the chroma average with clamp, whose register is the
// output register. the whole pipeline advances together whenever the output register is
// empty or being taken, so throughput is one word per clock while the sink keeps ready
// high, and a stall freezes every stage without loss. eye mode is written through the
// configuration channel (always ready) and should only change while no word is in flight;
// 0 is the left eye (red becomes the mean of green and blue), 1 the right eye (red zeroed).
`include "yuv420_block_anaglyph_filter_top_assert.svh"

module yuv420_block_anaglyph_filter_top (
	input logic   clk,
	input logic   arst_n,
	yaf_in_if.sink    blk,
	yaf_out_if.source res,
	yaf_cfg_if.sink   cfg
);
	import yaf_pkg::*;

	// stage valid bits travel with the data
	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;
	logic vld_s5;
	logic vld_s6;
	logic eye_mode_q;
	logic adv;
	pipe_ctrl_t ctrl;

	sample_t luma [NPIX];
	rgb_t    rgb_s2 [NPIX];
	sample_t y_s5 [NPIX];
	mag_t    u_s5 [NPIX];
	mag_t    v_s5 [NPIX];
	sample_t luma_s6 [NPIX];
	sample_t cb_s6;
	sample_t cr_s6;

	// global advance: the output register is free or being drained
	assign adv = !vld_s6 || res.ready;
	assign ctrl.adv = adv;
	assign ctrl.eye_mode = eye_mode_q;

	assign blk.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			eye_mode_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= blk.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// pixel order: top left, top right, bottom left, bottom right
	assign luma[0] = blk.luma_top_left;
	assign luma[1] = blk.luma_top_right;
	assign luma[2] = blk.luma_bottom_left;
	assign luma[3] = blk.luma_bottom_right;

	// stages 1 and 2: yuv to unclamped rgb
	yaf_rgb u_rgb (
		.clk    (clk),
		.ctrl   (ctrl),
		.luma   (luma),
		.cb     (blk.chroma_blue),
		.cr     (blk.chroma_red),
		.rgb_s2 (rgb_s2)
	);

	// stages 3 to 5: red edit and conversion back to yuv
	yaf_recode u_recode (
		.clk    (clk),
		.ctrl   (ctrl),
		.rgb_s2 (rgb_s2),
		.y_s5   (y_s5),
		.u_s5   (u_s5),
		.v_s5   (v_s5)
	);

	// stage 6: chroma average, output register
	yaf_avg u_avg (
		.clk     (clk),
		.ctrl    (ctrl),
		.y_s5    (y_s5),
		.u_s5    (u_s5),
		.v_s5    (v_s5),
		.luma_s6 (luma_s6),
		.cb_s6   (cb_s6),
		.cr_s6   (cr_s6)
	);

	assign res.valid = vld_s6;
	assign res.out_luma_top_left = luma_s6[0];
	assign res.out_luma_top_right = luma_s6[1];
	assign res.out_luma_bottom_left = luma_s6[2];
	assign res.out_luma_bottom_right = luma_s6[3];
	assign res.out_chroma_blue = cb_s6;
	assign res.out_chroma_red = cr_s6;

	// an empty output register never blocks the input
	`YAF_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !res.valid, blk.ready)
	// an accepted word occupies the first stage next cycle
	`YAF_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, blk.valid && blk.ready, vld_s1)
	// a word in the last inner stage reaches the output when the pipe advances
	`YAF_ASSERT_NEXT(a_s5_reaches_out, clk, arst_n, vld_s5 && adv, res.valid)
	// a stall freezes every stage
	`YAF_ASSERT_NEXT(a_stall_freezes, clk, arst_n, !adv,
		$stable({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6}))

endmodule

// ===== tb/yuv420_block_anaglyph_filter_top_test.sv =====
`timescale 1ns / 1ps

module yuv420_block_anaglyph_filter_top_test;
	import yaf_pkg::sample_t;

	// pipeline depth from accept to output register
	localparam int LATENCY = 6;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_GAP = 14;
	localparam int FRAC = 13;

	// forward path, yuv to rgb
	localparam int K_Y = 9535;
	localparam int K_RV = 13074;
	localparam int K_GV = 6660;
	localparam int K_GU = 3203;
	localparam int K_BU = 16531;

	// back path, rgb to yuv
	localparam int K_YR = 2104;
	localparam int K_YG = 4130;
	localparam int K_YB = 802;
	localparam int K_UR = -1214;
	localparam int K_UG = -2384;
	localparam int K_UB = 3598;
	localparam int K_VR = 3598;
	localparam int K_VG = -3013;
	localparam int K_VB = -585;
	localparam int RND_Y = 4096 + 131072;
	localparam int RND_C = 4096 + 1048576;

	typedef enum logic {
		EYE_LEFT  = 1'b0,
		EYE_RIGHT = 1'b1
	} eye_t;

	typedef struct packed {
		sample_t luma_top_left;
		sample_t luma_top_right;
		sample_t luma_bottom_left;
		sample_t luma_bottom_right;
		sample_t chroma_blue;
		sample_t chroma_red;
	} block_t;

	typedef struct packed {
		sample_t out_luma_top_left;
		sample_t out_luma_top_right;
		sample_t out_luma_bottom_left;
		sample_t out_luma_bottom_right;
		sample_t out_chroma_blue;
		sample_t out_chroma_red;
	} filtered_t;

	logic clk = 1'b0;
	logic arst_n;

	yaf_in_if blk();
	yaf_out_if res();
	yaf_cfg_if cfg();

	yuv420_block_anaglyph_filter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.blk(blk),
		.res(res),
		.cfg(cfg)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// blocks still in flight, oldest first
	filtered_t expected_words[$];
	// eye mode the block holds right now, as last written
	eye_t eye_now = EYE_LEFT;
	int n_mismatch = 0;
	// chance in percent that a word is preceded by an idle or stall run
	int src_gap_pct = 0;
	int sink_gap_pct = 0;

	// corner blocks: rail values, neutral chroma, negative rgb, odd sums, alternating bits
	block_t corner_blocks [11] = '{
		'{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
		'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
		'{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255},
		'{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255},
		'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0},
		'{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255},
		'{8'd16,  8'd235, 8'd0,   8'd255, 8'd128, 8'd128},
		'{8'd0,   8'd255, 8'd255, 8'd0,   8'd0,   8'd0},
		'{8'd1,   8'd2,   8'd3,   8'd4,   8'd0,   8'd128},
		'{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128},
		'{8'hAA,  8'h55,  8'hAA,  8'h55,  8'h55,  8'hAA}
	};

	function automatic sample_t sat8(input int x);
		if (x < 0)
			return 8'd0;
		if (x > 255)
			return 8'd255;
		return x[7:0];
	endfunction

	// magnitude of the rounded sum, then drop the fraction
	function automatic int mag_shift(input int x);
		return ((x < 0) ? -x : x) >> FRAC;
	endfunction

	// one 2x2 block through yuv -> rgb -> red edit -> yuv
	function automatic filtered_t filter_block(input block_t w, input eye_t eye);
		int lum [4];
		int ut, vt, yt, r, g, b, usum, vsum;
		sample_t lo [4];
		filtered_t o;
		lum = '{w.luma_top_left, w.luma_top_right, w.luma_bottom_left, w.luma_bottom_right};
		ut = int'(w.chroma_blue) - 128;
		vt = int'(w.chroma_red) - 128;
		usum = 0;
		vsum = 0;
		for (int i = 0; i < 4; i++) begin
			yt = K_Y * (lum[i] - 16);
			// arithmetic shift floors negative channels
			r = (yt + K_RV * vt) >>> FRAC;
			g = (yt - K_GV * vt - K_GU * ut) >>> FRAC;
			b = (yt + K_BU * ut) >>> FRAC;
			// left eye: mean of green and blue, truncated toward zero
			r = (eye == EYE_LEFT) ? (g + b) / 2 : 0;
			usum += mag_shift(r * K_UR + g * K_UG + b * K_UB + RND_C);
			vsum += mag_shift(r * K_VR + g * K_VG + b * K_VB + RND_C);
			lo[i] = sat8(mag_shift(r * K_YR + g * K_YG + b * K_YB + RND_Y));
		end
		o.out_luma_top_left = lo[0];
		o.out_luma_top_right = lo[1];
		o.out_luma_bottom_left = lo[2];
		o.out_luma_bottom_right = lo[3];
		o.out_chroma_blue = sat8(usum / 4);
		o.out_chroma_red = sat8(vsum / 4);
		return o;
	endfunction

	function automatic int draw_gap(input int pct);
		if ($urandom_range(0, 99) < pct)
			return $urandom_range(1, MAX_GAP);
		return 0;
	endfunction

	// rails show up more often than a flat draw would give
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return sample_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic block_t random_block();
		block_t w;
		w.luma_top_left = pick_sample();
		w.luma_top_right = pick_sample();
		w.luma_bottom_left = pick_sample();
		w.luma_bottom_right = pick_sample();
		w.chroma_blue = pick_sample();
		w.chroma_red = pick_sample();
		return w;
	endfunction

	// called right after a rising edge; returns at the edge that takes the word
	task automatic send_block(input block_t w);
		int gap;
		gap = draw_gap(src_gap_pct);
		if (gap > 0) begin
			blk.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		blk.valid <= 1'b1;
		blk.luma_top_left <= w.luma_top_left;
		blk.luma_top_right <= w.luma_top_right;
		blk.luma_bottom_left <= w.luma_bottom_left;
		blk.luma_bottom_right <= w.luma_bottom_right;
		blk.chroma_blue <= w.chroma_blue;
		blk.chroma_red <= w.chroma_red;
		do @(posedge clk); while (!blk.ready);
		expected_words.push_back(filter_block(w, eye_now));
	endtask

	// stop sending and let every word in flight come out
	task automatic wait_pipeline_empty();
		blk.valid <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
	endtask

	// only legal while nothing is in flight
	task automatic write_eye_mode(input eye_t eye);
		cfg.valid <= 1'b1;
		cfg.data <= eye;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		eye_now = eye;
	endtask

	// eye mode out of reset must be left eye
	task automatic test_reset_default();
		src_gap_pct = 0;
		sink_gap_pct = 0;
		send_block(corner_blocks[1]);
		send_block(corner_blocks[8]);
	endtask

	// rails, neutral chroma, floor of negative rgb, clamps, in both eye modes
	task automatic test_directed_extremes();
		eye_t eyes [2];
		eyes = '{EYE_RIGHT, EYE_LEFT};
		src_gap_pct = 30;
		sink_gap_pct = 30;
		foreach (eyes[e]) begin
			wait_pipeline_empty();
			write_eye_mode(eyes[e]);
			foreach (corner_blocks[k])
				send_block(corner_blocks[k]);
		end
	endtask

	// random blocks, eye mode and idle density changed between runs
	task automatic test_random_blocks();
		eye_t eye;
		for (int c = 0; c < 12; c++) begin
			wait_pipeline_empty();
			if (c < 2)
				eye = (c == 0) ? EYE_RIGHT : EYE_LEFT;
			else
				eye = eye_t'($urandom_range(0, 1));
			write_eye_mode(eye);
			src_gap_pct = 25 * $urandom_range(0, 4);
			sink_gap_pct = 25 * $urandom_range(0, 4);
			repeat (135) send_block(random_block());
		end
	endtask

	// full rate both sides, one word per clock
	task automatic test_back_to_back();
		src_gap_pct = 0;
		sink_gap_pct = 0;
		wait_pipeline_empty();
		write_eye_mode(EYE_LEFT);
		repeat (75) send_block(random_block());
		wait_pipeline_empty();
		write_eye_mode(EYE_RIGHT);
		repeat (75) send_block(random_block());
	endtask

	task automatic check_field(input string name, input sample_t want, input sample_t got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
			n_mismatch++;
		end
	endtask

	// result sink: random stall runs before each word, ready held until taken
	initial begin : sink_side
		int stall;
		@(posedge arst_n);
		forever begin
			stall = draw_gap(sink_gap_pct);
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	// compare every taken word against the oldest prediction
	initial begin : result_check
		filtered_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t unexpected word: expected none, got %h %h %h %h %h %h", $time,
						res.out_luma_top_left, res.out_luma_top_right,
						res.out_luma_bottom_left, res.out_luma_bottom_right,
						res.out_chroma_blue, res.out_chroma_red);
					n_mismatch++;
				end else begin
					want = expected_words.pop_front();
					check_field("out_luma_top_left", want.out_luma_top_left,
						res.out_luma_top_left);
					check_field("out_luma_top_right", want.out_luma_top_right,
						res.out_luma_top_right);
					check_field("out_luma_bottom_left", want.out_luma_bottom_left,
						res.out_luma_bottom_left);
					check_field("out_luma_bottom_right", want.out_luma_bottom_right,
						res.out_luma_bottom_right);
					check_field("out_chroma_blue", want.out_chroma_blue, res.out_chroma_blue);
					check_field("out_chroma_red", want.out_chroma_red, res.out_chroma_red);
				end
			end
		end
	end

	// hard stop if the pipeline hangs
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		// every input known from time zero
		blk.valid = 1'b0;
		blk.luma_top_left = '0;
		blk.luma_top_right = '0;
		blk.luma_bottom_left = '0;
		blk.luma_bottom_right = '0;
		blk.chroma_blue = '0;
		blk.chroma_red = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_default();
		test_directed_extremes();
		test_random_blocks();
		test_back_to_back();

		// drain, then give any stray word time to show up
		wait_pipeline_empty();
		repeat (4 * LATENCY) @(posedge clk);
		if (n_mismatch == 0 && expected_words.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
